// ===== rtl/core/phg_pkg.sv =====
// shared types and constants for the pressure hysteresis governor
package phg_pkg;

  localparam int USAGE_WIDTH_DEF = 48;
  localparam int BUDGET_W        = 48;
  localparam int PCT_W           = 20;
  localparam int DWELL_W         = 16;
  localparam int TICK_W          = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 48;

  localparam logic [PCT_W-1:0] PCT_CAP = 20'd1000000;

  localparam logic [PCT_W-1:0]   RST_HIGH_MARK   = 20'd90;
  localparam logic [PCT_W-1:0]   RST_LOW_MARK    = 20'd75;
  localparam logic [DWELL_W-1:0] RST_HIGH_DWELL  = 16'd3;
  localparam logic [DWELL_W-1:0] RST_LOW_DWELL   = 16'd3;
  localparam logic [DWELL_W-1:0] RST_EVICT_PER   = 16'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_DISABLED,
    STAT_NO_BUDGET,
    STAT_NO_SAMPLE
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_STOP,
    ACT_RESUME
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE,
    REG_BUDGET,
    REG_HIGH_MARK,
    REG_LOW_MARK,
    REG_HIGH_DWELL,
    REG_LOW_DWELL,
    REG_EVICT_PERIOD
  } cfg_reg_t;

endpackage

// ===== rtl/core/pressure_hysteresis_governor.sv =====
// memory pressure governor: bit-serial percent divider and watermark hysteresis
// one input word is taken at a time: in_ready stays low until the result has been
// handed to the output register; the restoring divider makes one quotient bit per
// cycle, with the tick-period remainder worked out bit by bit alongside it
// synchronous active-low reset clears the sequencer, output valid and governor
// state, and loads the configuration reset values
module pressure_hysteresis_governor #(
  parameter int USAGE_WIDTH = phg_pkg::USAGE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [phg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [phg_pkg::CFG_DATA_W-1:0]  cfg_data,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [USAGE_WIDTH-1:0]          in_usage_bytes,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic                            out_level_high,
  output logic [phg_pkg::PCT_W-1:0]       out_pressure_pct,
  output logic [1:0]                      out_action,
  output logic                            out_evict_due,
  output logic                            out_first_unavailable
);

  localparam int DW     = USAGE_WIDTH + 7;
  localparam int NSTEP  = (DW > phg_pkg::TICK_W) ? DW : phg_pkg::TICK_W;
  localparam int STEP_W = $clog2(NSTEP + 1);
  localparam int BW     = phg_pkg::BUDGET_W;
  localparam int PW     = phg_pkg::PCT_W;
  localparam int WW     = phg_pkg::DWELL_W;
  localparam int TW     = phg_pkg::TICK_W;

  // configuration
  logic          enable_r;
  logic [BW-1:0] budget_r;
  logic [PW-1:0] high_mark_r;
  logic [PW-1:0] low_mark_r;
  logic [WW-1:0] high_dwell_r;
  logic [WW-1:0] low_dwell_r;
  logic [WW-1:0] evict_per_r;

  // governor state
  logic          level_r, level_nxt;
  logic [WW-1:0] high_run_r, high_run_nxt;
  logic [WW-1:0] low_run_r, low_run_nxt;
  logic [TW-1:0] ticks_r, ticks_nxt;
  logic [PW-1:0] last_pct_r, last_pct_nxt;
  logic          unavail_r, unavail_nxt;

  // sequencer and serial datapath
  phg_pkg::state_t    state_r, state_nxt;
  logic [STEP_W-1:0]  step_r;
  logic [USAGE_WIDTH-1:0] usage_r;
  logic [NSTEP-1:0]   dvd_r;
  logic [BW-1:0]      rem_r;
  logic [PW-1:0]      quo_r;
  logic               ovf_r;
  logic [NSTEP-1:0]   mdvd_r;
  logic [WW-1:0]      mrem_r;

  logic               div_run;
  logic               fin_go;
  logic               load_word;

  // output register
  logic               out_valid_r;
  phg_pkg::status_t   status_r, status_nxt;
  logic               level_out_r;
  logic [PW-1:0]      pct_out_r, pct_out_nxt;
  phg_pkg::action_t   action_r, action_nxt;
  logic               evict_r, evict_nxt;
  logic               first_r, first_nxt;

  // effective dwell and period
  logic [WW-1:0] hd, ld, ep;
  assign hd = (high_dwell_r == '0) ? WW'(1) : high_dwell_r;
  assign ld = (low_dwell_r == '0) ? WW'(1) : low_dwell_r;
  assign ep = (evict_per_r == '0) ? WW'(1) : evict_per_r;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      budget_r     <= '0;
      high_mark_r  <= phg_pkg::RST_HIGH_MARK;
      low_mark_r   <= phg_pkg::RST_LOW_MARK;
      high_dwell_r <= phg_pkg::RST_HIGH_DWELL;
      low_dwell_r  <= phg_pkg::RST_LOW_DWELL;
      evict_per_r  <= phg_pkg::RST_EVICT_PER;
    end else if (cfg_valid && cfg_ready) begin
      unique case (phg_pkg::cfg_reg_t'(cfg_index))
        phg_pkg::REG_ENABLE:       enable_r     <= cfg_data[0];
        phg_pkg::REG_BUDGET:       budget_r     <= cfg_data[BW-1:0];
        phg_pkg::REG_HIGH_MARK:    high_mark_r  <= cfg_data[PW-1:0];
        phg_pkg::REG_LOW_MARK:     low_mark_r   <= cfg_data[PW-1:0];
        phg_pkg::REG_HIGH_DWELL:   high_dwell_r <= cfg_data[WW-1:0];
        phg_pkg::REG_LOW_DWELL:    low_dwell_r  <= cfg_data[WW-1:0];
        phg_pkg::REG_EVICT_PERIOD: evict_per_r  <= cfg_data[WW-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      phg_pkg::ST_IDLE: if (in_valid) state_nxt = phg_pkg::ST_MUL;
      phg_pkg::ST_MUL:  state_nxt = phg_pkg::ST_DIV;
      phg_pkg::ST_DIV:  if (step_r == STEP_W'(1)) state_nxt = phg_pkg::ST_FIN;
      phg_pkg::ST_FIN:  if (!out_valid_r || out_ready) state_nxt = phg_pkg::ST_IDLE;
      default:          state_nxt = phg_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    load_word = 1'b0;
    div_run   = 1'b0;
    fin_go    = 1'b0;
    unique case (state_r)
      phg_pkg::ST_IDLE: in_ready  = rst_n;
      phg_pkg::ST_MUL:  load_word = 1'b1;
      phg_pkg::ST_DIV:  div_run   = 1'b1;
      phg_pkg::ST_FIN:  fin_go    = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= phg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // serial datapath
  logic [NSTEP-1:0] u_ext;
  logic [TW-1:0]    tick_inc;
  logic [BW:0]      rsh, rdiff;
  logic             rge;
  logic [WW:0]      msh, mdiff;
  logic             mge;

  assign u_ext    = NSTEP'(in_usage_bytes);
  assign tick_inc = ticks_r + TW'(1);
  assign rsh      = {rem_r, dvd_r[NSTEP-1]};
  assign rge      = rsh >= {1'b0, budget_r};
  assign rdiff    = rsh - {1'b0, budget_r};
  assign msh      = {mrem_r, mdvd_r[NSTEP-1]};
  assign mge      = msh >= {1'b0, ep};
  assign mdiff    = msh - {1'b0, ep};

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      usage_r <= in_usage_bytes;
      // usage * 96 now, usage * 4 added next cycle
      dvd_r   <= (u_ext << 6) + (u_ext << 5);
    end else if (load_word) begin
      dvd_r   <= dvd_r + (NSTEP'(usage_r) << 2);
      rem_r   <= '0;
      quo_r   <= '0;
      ovf_r   <= 1'b0;
      mdvd_r  <= NSTEP'(tick_inc);
      mrem_r  <= '0;
      step_r  <= STEP_W'(NSTEP);
    end else if (div_run) begin
      dvd_r   <= dvd_r << 1;
      rem_r   <= rge ? rdiff[BW-1:0] : rsh[BW-1:0];
      quo_r   <= {quo_r[PW-2:0], rge};
      ovf_r   <= ovf_r | quo_r[PW-1];
      mdvd_r  <= mdvd_r << 1;
      mrem_r  <= mge ? mdiff[WW-1:0] : msh[WW-1:0];
      step_r  <= step_r - STEP_W'(1);
    end
  end

  // hysteresis update
  logic [PW-1:0] pct;
  logic [WW-1:0] hr_inc, lr_inc;

  assign pct    = (ovf_r || (quo_r > phg_pkg::PCT_CAP)) ? phg_pkg::PCT_CAP : quo_r;
  assign hr_inc = (high_run_r == '1) ? high_run_r : high_run_r + WW'(1);
  assign lr_inc = (low_run_r == '1) ? low_run_r : low_run_r + WW'(1);

  always_comb begin
    level_nxt    = level_r;
    high_run_nxt = high_run_r;
    low_run_nxt  = low_run_r;
    ticks_nxt    = ticks_r;
    last_pct_nxt = last_pct_r;
    unavail_nxt  = unavail_r;
    status_nxt   = phg_pkg::STAT_OK;
    pct_out_nxt  = '0;
    action_nxt   = phg_pkg::ACT_NONE;
    evict_nxt    = 1'b0;
    first_nxt    = 1'b0;
    if (!enable_r) begin
      status_nxt   = phg_pkg::STAT_DISABLED;
      level_nxt    = 1'b0;
      last_pct_nxt = '0;
    end else if (budget_r == '0) begin
      status_nxt   = phg_pkg::STAT_NO_BUDGET;
      level_nxt    = 1'b0;
      last_pct_nxt = '0;
      first_nxt    = !unavail_r;
      unavail_nxt  = 1'b1;
    end else if (usage_r == '0) begin
      status_nxt   = phg_pkg::STAT_NO_SAMPLE;
      pct_out_nxt  = last_pct_r;
    end else begin
      pct_out_nxt  = pct;
      last_pct_nxt = pct;
      if (pct >= high_mark_r) begin
        high_run_nxt = hr_inc;
        low_run_nxt  = '0;
        if (!level_r && (hr_inc >= hd)) begin
          level_nxt  = 1'b1;
          action_nxt = phg_pkg::ACT_STOP;
        end
      end else if (pct <= low_mark_r) begin
        low_run_nxt  = lr_inc;
        high_run_nxt = '0;
        if (level_r && (lr_inc >= ld)) begin
          level_nxt  = 1'b0;
          action_nxt = phg_pkg::ACT_RESUME;
        end
      end else begin
        high_run_nxt = '0;
        low_run_nxt  = '0;
      end
      if (level_nxt) begin
        ticks_nxt = tick_inc;
        evict_nxt = (tick_inc != '0) && (mrem_r == '0);
      end else begin
        ticks_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= 1'b0;
      high_run_r <= '0;
      low_run_r  <= '0;
      ticks_r    <= '0;
      last_pct_r <= '0;
      unavail_r  <= 1'b0;
    end else if (fin_go) begin
      level_r    <= level_nxt;
      high_run_r <= high_run_nxt;
      low_run_r  <= low_run_nxt;
      ticks_r    <= ticks_nxt;
      last_pct_r <= last_pct_nxt;
      unavail_r  <= unavail_nxt;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      status_r    <= status_nxt;
      level_out_r <= level_nxt;
      pct_out_r   <= pct_out_nxt;
      action_r    <= action_nxt;
      evict_r     <= evict_nxt;
      first_r     <= first_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_level_high        = level_out_r;
  assign out_pressure_pct      = pct_out_r;
  assign out_action            = action_r;
  assign out_evict_due         = evict_r;
  assign out_first_unavailable = first_r;

endmodule
